/* src/ahpc_pkg.sv */
// shared types, codes and constants of the homing position controller
package ahpc_pkg;

   // event codes carried in the request tuser field
   typedef enum logic [2:0] {
      EV_TICK      = 3'd0,
      EV_HIT_FWD   = 3'd1,
      EV_HIT_BWD   = 3'd2,
      EV_MOVE_TO   = 3'd3,
      EV_JOG       = 3'd4,
      EV_CALIBRATE = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      DRV_STOP = 2'd0,
      DRV_FWD  = 2'd1,
      DRV_BWD  = 2'd2
   } drive_type;

   // axis mode, one-hot internally
   typedef enum logic [4:0] {
      MODE_NORMAL   = 5'b00001,
      MODE_CAL_FWD  = 5'b00010,
      MODE_CAL_BWD  = 5'b00100,
      MODE_CAL_FREE = 5'b01000,
      MODE_CAL_FIND = 5'b10000
   } mode_type;

   localparam int EVENT_W = 3;
   localparam int DIR_W   = 2;
   localparam int MOVE_W  = 16;

   // jog and calibrate direction requests
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BWD  = 2'd2;

   // axis state codes on the result channel
   localparam logic [2:0] CODE_NORMAL   = 3'd0;
   localparam logic [2:0] CODE_CAL_FWD  = 3'd1;
   localparam logic [2:0] CODE_CAL_BWD  = 3'd2;
   localparam logic [2:0] CODE_CAL_FREE = 3'd3;
   localparam logic [2:0] CODE_CAL_FIND = 3'd4;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_MIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_MAX  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_MOVE = 2'd2;

   localparam logic [MOVE_W-1:0] MIN_MOVE_RESET = 16'd1500;

   typedef struct packed {
      mode_type  mode;
      drive_type drive;
      logic      cal;
   } axis_state_type;

   // result item, drive in the lowest bits
   typedef struct packed {
      logic      calibrated;
      logic      clear_encoder;
      logic      reached;
      logic [2:0] axis_state;
      drive_type drive;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

   localparam axis_state_type AXIS_STATE_RESET = '{
      mode:  MODE_NORMAL,
      drive: DRV_STOP,
      cal:   1'b0
   };

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      case (m)
         MODE_NORMAL:   code = CODE_NORMAL;
         MODE_CAL_FWD:  code = CODE_CAL_FWD;
         MODE_CAL_BWD:  code = CODE_CAL_BWD;
         MODE_CAL_FREE: code = CODE_CAL_FREE;
         MODE_CAL_FIND: code = CODE_CAL_FIND;
         default:       code = CODE_NORMAL;
      endcase
      return code;
   endfunction

endpackage

/* src/ahpc_csr.sv */
// configuration registers: position limits and minimum move distance
module ahpc_csr #(
   parameter int POS_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [ahpc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [POS_WIDTH-1:0]                   csr_wdata,
   output logic signed [POS_WIDTH-1:0]            pos_min,
   output logic signed [POS_WIDTH-1:0]            pos_max,
   output logic [ahpc_pkg::MOVE_W-1:0]            min_move
);

   logic signed [POS_WIDTH-1:0] pos_min_ff, pos_min_in;
   logic signed [POS_WIDTH-1:0] pos_max_ff, pos_max_in;
   logic [ahpc_pkg::MOVE_W-1:0] min_move_ff, min_move_in;

   always_comb begin
      pos_min_in  = pos_min_ff;
      pos_max_in  = pos_max_ff;
      min_move_in = min_move_ff;
      if (csr_we) begin
         case (csr_index)
            ahpc_pkg::CSR_POS_MIN:  pos_min_in = csr_wdata;
            ahpc_pkg::CSR_POS_MAX:  pos_max_in = csr_wdata;
            ahpc_pkg::CSR_MIN_MOVE: min_move_in = csr_wdata[ahpc_pkg::MOVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_min_ff  <= {1'b1, {(POS_WIDTH-1){1'b0}}};
         pos_max_ff  <= {1'b0, {(POS_WIDTH-1){1'b1}}};
         min_move_ff <= ahpc_pkg::MIN_MOVE_RESET;
      end else begin
         pos_min_ff  <= pos_min_in;
         pos_max_ff  <= pos_max_in;
         min_move_ff <= min_move_in;
      end
   end

   assign pos_min  = pos_min_ff;
   assign pos_max  = pos_max_ff;
   assign min_move = min_move_ff;

endmodule

/* src/ahpc_step.sv */
// event logic: next axis state, target and result for one event
module ahpc_step #(
   parameter int POS_WIDTH = 32
) (
   input  ahpc_pkg::axis_state_type        state,
   input  logic signed [POS_WIDTH-1:0]     target,
   input  logic signed [POS_WIDTH-1:0]     pos_min,
   input  logic signed [POS_WIDTH-1:0]     pos_max,
   input  logic [ahpc_pkg::MOVE_W-1:0]     min_move,
   input  ahpc_pkg::event_type             ev,
   input  logic signed [POS_WIDTH-1:0]     position,
   input  logic                            switch_fwd_level,
   input  logic                            switch_bwd_level,
   input  logic signed [POS_WIDTH-1:0]     goal,
   input  logic [ahpc_pkg::DIR_W-1:0]      dir_request,
   output ahpc_pkg::axis_state_type        next_state,
   output logic signed [POS_WIDTH-1:0]     next_target,
   output ahpc_pkg::rsp_type               rsp
);

   logic signed [POS_WIDTH:0] diff;
   logic signed [POS_WIDTH:0] move_lim;
   logic                      far_fwd;
   logic                      far_bwd;
   logic                      in_range;
   logic                      stop_now;
   logic                      hit;
   logic                      reached;
   logic                      clr;

   // distance kept one bit wider so it cannot wrap
   assign diff     = {goal[POS_WIDTH-1], goal} - {position[POS_WIDTH-1], position};
   assign move_lim = $signed({{(POS_WIDTH+1-ahpc_pkg::MOVE_W){1'b0}}, min_move});
   assign far_fwd  = diff > move_lim;
   assign far_bwd  = diff < -move_lim;
   assign in_range = (goal >= pos_min) && (goal <= pos_max);

   assign stop_now =
      ((state.drive == ahpc_pkg::DRV_FWD) && ((position >= target) || (position >= pos_max))) ||
      ((state.drive == ahpc_pkg::DRV_BWD) && ((position <= target) || (position <= pos_min)));

   assign hit = ((ev == ahpc_pkg::EV_HIT_FWD) && (state.drive == ahpc_pkg::DRV_FWD)) ||
                ((ev == ahpc_pkg::EV_HIT_BWD) && (state.drive == ahpc_pkg::DRV_BWD));

   always_comb begin
      next_state  = state;
      next_target = target;
      reached     = 1'b0;
      clr         = 1'b0;
      case (ev)
         ahpc_pkg::EV_TICK: begin
            case (state.mode)
               ahpc_pkg::MODE_NORMAL: begin
                  if (stop_now) begin
                     next_state.drive = ahpc_pkg::DRV_STOP;
                     reached          = 1'b1;
                  end
               end
               ahpc_pkg::MODE_CAL_FWD: begin
                  if (switch_fwd_level) begin
                     next_state.mode  = ahpc_pkg::MODE_CAL_FREE;
                     next_state.drive = ahpc_pkg::DRV_BWD;
                  end else begin
                     next_state.mode  = ahpc_pkg::MODE_CAL_FIND;
                     next_state.drive = ahpc_pkg::DRV_FWD;
                  end
               end
               ahpc_pkg::MODE_CAL_BWD: begin
                  if (switch_bwd_level) begin
                     next_state.mode  = ahpc_pkg::MODE_CAL_FREE;
                     next_state.drive = ahpc_pkg::DRV_FWD;
                  end else begin
                     next_state.mode  = ahpc_pkg::MODE_CAL_FIND;
                     next_state.drive = ahpc_pkg::DRV_BWD;
                  end
               end
               ahpc_pkg::MODE_CAL_FREE: begin
                  // once off both switches, head back the other way to find the edge
                  if (!switch_fwd_level && !switch_bwd_level) begin
                     next_state.mode  = ahpc_pkg::MODE_CAL_FIND;
                     next_state.drive = (state.drive == ahpc_pkg::DRV_FWD) ?
                                        ahpc_pkg::DRV_BWD : ahpc_pkg::DRV_FWD;
                  end
               end
               default: ;
            endcase
         end
         ahpc_pkg::EV_HIT_FWD, ahpc_pkg::EV_HIT_BWD: begin
            if (hit) begin
               next_state.drive = ahpc_pkg::DRV_STOP;
               if (state.mode == ahpc_pkg::MODE_CAL_FIND) begin
                  clr             = 1'b1;
                  next_state.cal  = 1'b1;
                  next_state.mode = ahpc_pkg::MODE_NORMAL;
               end
            end
         end
         ahpc_pkg::EV_MOVE_TO: begin
            if (in_range) begin
               next_target = goal;
               if (far_fwd) begin
                  next_state.drive = ahpc_pkg::DRV_FWD;
               end else if (far_bwd) begin
                  next_state.drive = ahpc_pkg::DRV_BWD;
               end
            end
         end
         ahpc_pkg::EV_JOG: begin
            case (dir_request)
               ahpc_pkg::DIR_NONE: next_state.drive = ahpc_pkg::DRV_STOP;
               ahpc_pkg::DIR_FWD: begin
                  next_target      = {1'b0, {(POS_WIDTH-1){1'b1}}};
                  next_state.drive = ahpc_pkg::DRV_FWD;
               end
               ahpc_pkg::DIR_BWD: begin
                  next_target      = {1'b1, {(POS_WIDTH-1){1'b0}}};
                  next_state.drive = ahpc_pkg::DRV_BWD;
               end
               default: ;
            endcase
         end
         ahpc_pkg::EV_CALIBRATE: begin
            next_state.mode = (dir_request == ahpc_pkg::DIR_FWD) ?
                              ahpc_pkg::MODE_CAL_FWD : ahpc_pkg::MODE_CAL_BWD;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.drive         = next_state.drive;
      rsp.axis_state    = ahpc_pkg::mode_code(next_state.mode);
      rsp.reached       = reached;
      rsp.clear_encoder = clr;
      rsp.calibrated    = next_state.cal;
   end

endmodule

/* src/axis_homing_position_controller_top.sv */
// top level of the homing position controller: input and result registers
// One event per clock cycle while rsp_tready keeps the result register draining:
// each accepted transfer lands in an input register, the combinational event logic
// between that register and the result register updates the axis state as the
// event moves on, and the result is registered in the result register before it
// appears on rsp_. An empty input register takes a new request while a finished
// result still waits. Request tuser holds the event code; request
// tdata holds position, forward switch, backward switch, goal and direction from
// bit 0 up, zero-padded to whole bytes. Configuration writes are taken in any cycle
// and should only be issued while no event is in flight.
module axis_homing_position_controller_top #(
   parameter int POS_WIDTH = 32,
   localparam int REQ_DATA_W  = 2*POS_WIDTH + 4,
   localparam int REQ_TDATA_W = ((REQ_DATA_W + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // position, switch_fwd_level, switch_bwd_level, goal, dir_request
   input  logic [REQ_TDATA_W-1:0]             req_tdata,
   // event code
   input  logic [ahpc_pkg::EVENT_W-1:0]       req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // drive, axis_state, reached, clear_encoder, calibrated
   output logic [ahpc_pkg::RSP_W-1:0]         rsp_tdata,
   // configuration port
   input  logic                               csr_we,
   input  logic [ahpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [POS_WIDTH-1:0]               csr_wdata
);

   logic signed [POS_WIDTH-1:0]   pos_min;
   logic signed [POS_WIDTH-1:0]   pos_max;
   logic [ahpc_pkg::MOVE_W-1:0]   min_move;

   // input register
   logic                          s1_valid_ff, s1_valid_in;
   ahpc_pkg::event_type           s1_event_ff;
   logic signed [POS_WIDTH-1:0]   s1_pos_ff;
   logic                          s1_swf_ff;
   logic                          s1_swb_ff;
   logic signed [POS_WIDTH-1:0]   s1_goal_ff;
   logic [ahpc_pkg::DIR_W-1:0]    s1_dir_ff;

   // axis state
   ahpc_pkg::axis_state_type      state_ff, state_in;
   logic signed [POS_WIDTH-1:0]   target_ff, target_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   ahpc_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                          advance;
   logic                          req_take;

   ahpc_csr #(.POS_WIDTH(POS_WIDTH)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pos_min   (pos_min),
      .pos_max   (pos_max),
      .min_move  (min_move)
   );

   ahpc_step #(.POS_WIDTH(POS_WIDTH)) u_step (
      .state            (state_ff),
      .target           (target_ff),
      .pos_min          (pos_min),
      .pos_max          (pos_max),
      .min_move         (min_move),
      .ev               (s1_event_ff),
      .position         (s1_pos_ff),
      .switch_fwd_level (s1_swf_ff),
      .switch_bwd_level (s1_swb_ff),
      .goal             (s1_goal_ff),
      .dir_request      (s1_dir_ff),
      .next_state       (state_in),
      .next_target      (target_in),
      .rsp              (rsp_data_in)
   );

   // an event moves on when the result register is empty or being drained
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ahpc_pkg::AXIS_STATE_RESET;
         target_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff  <= state_in;
            target_ff <= target_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_event_ff <= ahpc_pkg::event_type'(req_tuser);
         s1_pos_ff   <= req_tdata[POS_WIDTH-1:0];
         s1_swf_ff   <= req_tdata[POS_WIDTH];
         s1_swb_ff   <= req_tdata[POS_WIDTH+1];
         s1_goal_ff  <= req_tdata[2*POS_WIDTH+1:POS_WIDTH+2];
         s1_dir_ff   <= req_tdata[2*POS_WIDTH+3:2*POS_WIDTH+2];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // a reported arrival always leaves the motor stopped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.reached |-> rsp_data_ff.drive == ahpc_pkg::DRV_STOP)
      else $error("reached reported with motor still driven");

   // encoder clear only on homing completion
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.clear_encoder |->
         rsp_data_ff.calibrated && rsp_data_ff.axis_state == ahpc_pkg::CODE_NORMAL)
      else $error("encoder clear without completed homing");

   // an event that moves on always shows up as a result
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced event produced no result");

   // calibration flag is sticky once set
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(state_ff.cal))
      else $error("calibration flag dropped");

   // the result register only changes when it is empty or drained
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_data_ff) && $stable(state_ff))
      else $error("stalled result or axis state changed");
`endif

endmodule
